// ===== rtl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg: shared definitions for the sorted list engine
// Command codes and the control bundle that the top level sends to every cell.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int unsigned CMD_W = 2;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_LOOKUP = 2'd2;
    localparam t_cmd CMD_CLEAR  = 2'd3;

    localparam int unsigned TOTAL_W = 7;

    // Control broadcast to every cell in the row.
    typedef struct packed {
        logic cmp_en;   // latch compare flags against the incoming key
        logic ins;      // open a gap and insert the key
        logic rmv;      // close the gap at the first equal entry
        logic clr;      // drop every entry
    } t_cell_ctl;

endpackage

// ===== rtl/sle_cell.sv =====
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted list
// Holds one entry and its valid bit, compares it against the request key and
// moves data to or from its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module sle_cell
    import sle_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [DATA_WIDTH-1:0] i_cmp_key,
    input  logic [DATA_WIDTH-1:0] i_ins_key,
    input  logic [DATA_WIDTH-1:0] i_left_data,
    input  logic                  i_left_valid,
    input  logic                  i_left_place,
    input  logic [DATA_WIDTH-1:0] i_right_data,
    input  logic                  i_right_valid,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic                  o_place,
    output logic                  o_eq
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_valid;
    logic                  n_valid;
    logic                  r_place;
    logic                  r_eq;

    // Decide this slot's next content from the latched flags.
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.clr) begin
            n_valid = 1'b0;
        end else if (i_ctl.ins) begin
            if (i_left_place) begin
                n_data  = i_left_data;
                n_valid = i_left_valid;
            end else if (r_place) begin
                n_data  = i_ins_key;
                n_valid = 1'b1;
            end
        end else if (i_ctl.rmv) begin
            if (r_place) begin
                n_data  = i_right_data;
                n_valid = i_right_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_place <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_ctl.cmp_en) begin
                // An empty slot counts as a place where the key fits.
                r_place <= ~r_valid | (r_data >= i_cmp_key);
                r_eq    <= r_valid & (r_data == i_cmp_key);
            end
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_place = r_place;
    assign o_eq    = r_eq;

endmodule

// ===== rtl/sorted_list_engine.sv =====
// ----------------------------------------------------------------------------
// sorted_list_engine: ordered list of up to CAPACITY unsigned values
// Insert, remove, lookup and clear over a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_cmd and i_value and raise start. A request is
//   taken at the rising edge where start is high and busy is low.
//   Commands: insert places the value in front of the first entry that is
//   greater or equal; remove drops the first equal entry; lookup only
//   reports; clear empties the list.
//   Result channel: o_strobe is high for exactly one cycle, the cycle after
//   the request is taken, with o_found (presence before the request, low for clear),
//   o_entry_total (count after the request, low 7 bits) and o_status
//   (1 when an insert hit a full list, which leaves the list unchanged).
//   Sequence: in the accept cycle all cells compare their entry with
//   i_value in parallel and latch the flags; then, in the apply state, the
//   flags steer one shift of the cell row and the result is shown. busy
//   is high in the apply state, so no new request is taken until the
//   current one has been applied.
//   The receiver cannot stall: the result must be taken when the strobe
//   is high.
//   Reset (synchronous, active low) empties the list; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_list_engine
    import sle_pkg::*;
#(
    parameter int unsigned CAPACITY   = 64,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [31:0]          i_value,
    output logic                 o_strobe,
    output logic                 o_found,
    output logic [TOTAL_W-1:0]   o_entry_total,
    output logic                 o_status
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // Two-state sequencer: wait for a request, then apply it.
    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_APPLY = 1'b1;

    logic                  r_state;
    logic                  n_state;
    t_cmd                  r_cmd;
    logic [DATA_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic                  w_accept;
    logic [DATA_WIDTH-1:0] w_key;
    t_cell_ctl             w_ctl;
    logic                  w_found;
    logic                  w_full;

    logic [DATA_WIDTH-1:0] w_data  [CAPACITY];
    logic [CAPACITY-1:0]   w_valid;
    logic [CAPACITY-1:0]   w_place;
    logic [CAPACITY-1:0]   w_eq;

    assign w_accept = start && (r_state == ST_IDLE);
    assign busy     = (r_state == ST_APPLY);

    // Keep the value modulo 2^DATA_WIDTH.
    assign w_key = DATA_WIDTH'(i_value);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Cells are ordered, so equal entries start right at the first
    // place position; any equal flag means the value is present.
    assign w_found = |w_eq;
    assign w_full  = (r_count == CNT_W'(CAPACITY));

    // Steer the row: compare on accept, shift or clear in the apply cycle.
    always_comb begin
        w_ctl        = '0;
        w_ctl.cmp_en = w_accept;
        if (r_state == ST_APPLY) begin
            w_ctl.ins = (r_cmd == CMD_INSERT) && !w_full;
            w_ctl.rmv = (r_cmd == CMD_REMOVE) && w_found;
            w_ctl.clr = (r_cmd == CMD_CLEAR);
        end
    end

    // Advance the count along with the shift.
    always_comb begin
        n_count = r_count;
        if (w_ctl.clr) begin
            n_count = '0;
        end else if (w_ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.rmv) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
            r_key <= w_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Row of cells: cell 0 is the smallest entry.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left_data;
        logic                  w_left_valid;
        logic                  w_left_place;
        logic [DATA_WIDTH-1:0] w_right_data;
        logic                  w_right_valid;

        if (g == 0) begin : g_head
            assign w_left_data  = r_key;
            assign w_left_valid = 1'b1;
            assign w_left_place = 1'b0;
        end else begin : g_body
            assign w_left_data  = w_data[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_place = w_place[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_data  = r_key;
            assign w_right_valid = 1'b0;
        end else begin : g_inner
            assign w_right_data  = w_data[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        sle_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_cmp_key    (w_key),
            .i_ins_key    (r_key),
            .i_left_data  (w_left_data),
            .i_left_valid (w_left_valid),
            .i_left_place (w_left_place),
            .i_right_data (w_right_data),
            .i_right_valid(w_right_valid),
            .o_data       (w_data[g]),
            .o_valid      (w_valid[g]),
            .o_place      (w_place[g]),
            .o_eq         (w_eq[g])
        );
    end

    // Result shows in the apply cycle only.
    assign o_strobe      = (r_state == ST_APPLY);
    assign o_found       = (r_cmd != CMD_CLEAR) && w_found;
    assign o_entry_total = TOTAL_W'(n_count);
    assign o_status      = (r_cmd == CMD_INSERT) && w_full;

endmodule
